### rtl/fwam_pkg.sv
`default_nettype none

package fwam_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned LIDX_W   = 6;
  localparam int unsigned LIMIT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_TEXT    = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [LETTER_W-1:0] letter;
  } item_t;

  typedef struct packed {
    logic rejected;
    logic found;
    logic match_here;
  } res_t;

endpackage

`default_nettype wire

### rtl/fixed_window_anagram_match.sv
// Anagram search over a letter stream. Send a clear request (tuser 0), then pattern letters
// (tuser 1), then text letters (tuser 2); letters are 0 for a up to ALPHABET_SIZE-1. Every
// request gives exactly one result: match_here when the last pattern-length text letters are
// a permutation of the pattern, a sticky found flag, and rejected for a pattern letter that
// came with the pattern full, after text, or out of range. One request is taken per clock
// unless the output is stalled; a result leaves through an input register and a result
// register, with the window update, the ring read of the oldest letter and the per-letter
// compare over ALPHABET_SIZE bins all done combinationally between them. The ring of recent
// letters is a RAM whose read is registered and issued from the next state.
`default_nettype none

module fixed_window_anagram_match #(
  parameter int unsigned MAX_PATTERN   = 32,
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // letter [4:0]
  input  wire logic [1:0] s_axis_tuser,   // command [1:0]
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata    // match_here [0], found [1], rejected [2]
);

  logic            in_vld_q, in_vld_d;
  fwam_pkg::item_t in_item_q;
  logic            out_vld_q, out_vld_d;
  fwam_pkg::res_t  out_res_q, res;
  logic            advance, in_fire;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_vld_d      = in_fire || (in_vld_q && !advance);
  assign out_vld_d     = advance || (out_vld_q && !m_axis_tready);

  fwam_core #(
    .MAX_PATTERN   (MAX_PATTERN),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_item_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q.command <= s_axis_tuser;
      in_item_q.letter  <= s_axis_tdata[fwam_pkg::LETTER_W-1:0];
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, out_res_q.rejected, out_res_q.found, out_res_q.match_here};

`ifndef SYNTHESIS
  a_match_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_res_q.match_here |-> out_res_q.found)
    else $error("match without found flag");

  a_match_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_res_q.match_here && out_res_q.rejected))
    else $error("match and reject on one result");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_vld_q && out_vld_q && !m_axis_tready)
    else $error("input stalled without output back-pressure");
`endif

endmodule

`default_nettype wire

### rtl/fwam_ram.sv
`default_nettype none

module fwam_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/fwam_core.sv
`default_nettype none

module fwam_core #(
  parameter int unsigned MAX_PATTERN   = 32,
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire fwam_pkg::item_t item_i,
  output fwam_pkg::res_t      res_o
);

  localparam int unsigned CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PATTERN);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_PATTERN - 1);
  localparam logic [SUM_W-1:0] MAX_SUM = SUM_W'(MAX_PATTERN);
  localparam logic [fwam_pkg::LIMIT_W-1:0] ALPHA_LIM =
    fwam_pkg::LIMIT_W'(ALPHABET_SIZE);

  logic [CNT_W-1:0] pcnt_q [ALPHABET_SIZE];
  logic [CNT_W-1:0] pcnt_d [ALPHABET_SIZE];
  logic [CNT_W-1:0] wcnt_q [ALPHABET_SIZE];
  logic [CNT_W-1:0] wcnt_d [ALPHABET_SIZE];
  logic [CNT_W-1:0] plen_q, plen_d;
  logic [CNT_W-1:0] seen_q, seen_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic             found_q, found_d;
  logic [fwam_pkg::LETTER_W-1:0] last_q, last_d;

  logic is_clear, is_pat, is_text, pat_ok, letter_ok, full, hit, eq_all;
  logic [fwam_pkg::LETTER_W-1:0] old_raw, ram_rdata;
  logic [fwam_pkg::LIDX_W-1:0]   old_idx, cur_idx;
  logic [ALPHABET_SIZE-1:0]      eq_vec;
  logic [CNT_W-1:0] plen_nx;
  logic [PTR_W-1:0] ptr_nx;
  logic [SUM_W-1:0] back_sum, back_wrap;
  logic [PTR_W-1:0] raddr;

  always_comb begin
    is_clear = 1'b0;
    is_pat   = 1'b0;
    is_text  = 1'b0;
    unique case (item_i.command)
      fwam_pkg::CMD_CLEAR:   is_clear = 1'b1;
      fwam_pkg::CMD_PATTERN: is_pat   = 1'b1;
      fwam_pkg::CMD_TEXT:    is_text  = 1'b1;
      default: ;
    endcase
  end

  assign letter_ok = {2'b00, item_i.letter} < ALPHA_LIM;
  assign pat_ok    = is_pat && letter_ok && (plen_q != MAX_CNT) && (seen_q == '0);
  assign full      = seen_q >= plen_q;
  assign cur_idx   = {1'b0, item_i.letter};

  // oldest letter of the window: none yet, the previous letter, or the ring
  always_comb begin
    if (plen_q == '0) begin
      old_raw = item_i.letter;
    end else if (plen_q == CNT_W'(1)) begin
      old_raw = last_q;
    end else begin
      old_raw = ram_rdata;
    end
    if ({2'b00, old_raw} < ALPHA_LIM) begin
      old_idx = {1'b0, old_raw};
    end else begin
      old_idx = '0;
    end
  end

  for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_bin
    logic inc_w, dec_w, inc_p;
    assign inc_w = is_text && letter_ok && (cur_idx == fwam_pkg::LIDX_W'(k));
    assign dec_w = is_text && letter_ok && full && (old_idx == fwam_pkg::LIDX_W'(k));
    assign inc_p = pat_ok && (cur_idx == fwam_pkg::LIDX_W'(k));
    assign wcnt_d[k] = is_clear ? '0
                     : CNT_W'(SUM_W'(wcnt_q[k]) + SUM_W'(inc_w) - SUM_W'(dec_w));
    assign pcnt_d[k] = is_clear ? '0 : CNT_W'(SUM_W'(pcnt_q[k]) + SUM_W'(inc_p));
    assign eq_vec[k] = pcnt_q[k] == wcnt_d[k];
  end

  assign eq_all = &eq_vec;

  always_comb begin
    plen_d  = is_clear ? '0 : CNT_W'(SUM_W'(plen_q) + SUM_W'(pat_ok));
    seen_d  = seen_q;
    ptr_d   = ptr_q;
    last_d  = last_q;
    if (is_clear) begin
      seen_d = '0;
      ptr_d  = '0;
    end else if (is_text && letter_ok) begin
      if (seen_q != MAX_CNT) begin
        seen_d = CNT_W'(SUM_W'(seen_q) + SUM_W'(1));
      end
      ptr_d  = (ptr_q == PTR_LAST) ? '0 : PTR_W'(ptr_q + PTR_W'(1));
      last_d = item_i.letter;
    end
    hit     = is_text && letter_ok && (seen_d >= plen_q) && eq_all;
    found_d = is_clear ? 1'b0 : (found_q | hit);
  end

  // ring read for the state the next item will see
  assign plen_nx   = step_i ? plen_d : plen_q;
  assign ptr_nx    = step_i ? ptr_d : ptr_q;
  assign back_sum  = SUM_W'(ptr_nx) + MAX_SUM - SUM_W'(plen_nx);
  assign back_wrap = (back_sum >= MAX_SUM) ? SUM_W'(back_sum - MAX_SUM) : back_sum;
  assign raddr     = PTR_W'(back_wrap);

  fwam_ram #(
    .WIDTH (fwam_pkg::LETTER_W),
    .DEPTH (MAX_PATTERN)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (step_i && is_text && letter_ok),
    .waddr_i (ptr_q),
    .wdata_i (item_i.letter),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ALPHABET_SIZE; k++) begin
        pcnt_q[k] <= '0;
        wcnt_q[k] <= '0;
      end
      plen_q  <= '0;
      seen_q  <= '0;
      ptr_q   <= '0;
      found_q <= 1'b0;
      last_q  <= '0;
    end else if (step_i) begin
      for (int k = 0; k < ALPHABET_SIZE; k++) begin
        pcnt_q[k] <= pcnt_d[k];
        wcnt_q[k] <= wcnt_d[k];
      end
      plen_q  <= plen_d;
      seen_q  <= seen_d;
      ptr_q   <= ptr_d;
      found_q <= found_d;
      last_q  <= last_d;
    end
  end

  assign res_o.match_here = hit;
  assign res_o.found      = found_d;
  assign res_o.rejected   = is_pat && !pat_ok;

`ifndef SYNTHESIS
  a_seen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= MAX_CNT && plen_q <= MAX_CNT)
    else $error("text or pattern count beyond capacity");

  a_clear_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && is_clear |=> !found_q && seen_q == '0 && plen_q == '0)
    else $error("clear left search state behind");

  a_pattern_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q != '0 |=> $stable(plen_q) || $past(step_i && is_clear))
    else $error("pattern grew after text started");
`endif

endmodule

`default_nettype wire
